FILE: hw/rtl/rqkr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqkr_pkg: shared types for the request queue with keyed remove
// Command and status codes, the request and response words, the stored
// entry and the control group that the sequencer hands to every cell.
// ----------------------------------------------------------------------------
package rqkr_pkg;

  // Default queue depth.
  localparam int DEPTH_DEFAULT = 16;

  // Field widths of the interface words.
  localparam int KEY_W   = 10;
  localparam int STAMP_W = 32;
  localparam int COUNT_W = 5;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_APPEND     = 2'd0,
    CMD_POP_HEAD   = 2'd1,
    CMD_POP_TAIL   = 2'd2,
    CMD_REMOVE_KEY = 2'd3
  } cmd_t;

  // Status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } state_t;

  // Input word.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [KEY_W-1:0]   key_fd;
    logic [STAMP_W-1:0] arrival_stamp;
  } req_t;

  // Result word.
  typedef struct packed {
    logic [1:0]         status;
    logic [KEY_W-1:0]   out_fd;
    logic [STAMP_W-1:0] out_stamp;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  // One stored queue entry.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Control group broadcast to the cells.
  typedef struct packed {
    logic shift;  // every cell not addressed by a load takes the entry of the cell behind it
    logic load;   // the addressed cell takes the load entry
  } cell_ctl_t;

endpackage

FILE: hw/rtl/request_queue_with_keyed_remove_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_queue_with_keyed_remove_core: ordered request queue
// A row of cells holds the queue, head in cell 0. Entries move one cell per
// shift; removal from the middle closes up the order of the rest.
//
//   Channel   Ports                 Handshake
//   command   start, busy, req      word taken when start is high, busy low
//   result    done, rsp             word valid for the single cycle of done
//
// For append and remove-head, done is high in the next cycle.
// Remove-tail and keyed remove rotate the queue through the head cell, one
// entry per cycle: busy while each held entry is rotated once, then done. On an
// empty queue every command finishes without a walk.
// Reset clears the entry count; the cells need no clearing.
// The receiver cannot stall: each result is shown once, for one cycle.
// ----------------------------------------------------------------------------
module request_queue_with_keyed_remove_core #(
  parameter int DEPTH = rqkr_pkg::DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rqkr_pkg::req_t   req,
  output logic             busy,
  output logic             done,
  output rqkr_pkg::rsp_t   rsp
);
  import rqkr_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  cell_ctl_t           ctl;
  logic [IDX_W-1:0]    target;
  entry_t              load_word;
  entry_t              chain [DEPTH+1];

  // Command sequencer.
  rqkr_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .head      (chain[0]),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp),
    .ctl       (ctl),
    .target    (target),
    .load_word (load_word)
  );

  // Nothing lies behind the last cell.
  assign chain[DEPTH] = '0;

  // Row of cells, each fed by its neighbor toward the tail.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rqkr_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .target    (target),
      .load_word (load_word),
      .next_word (chain[i+1]),
      .word      (chain[i])
    );
  end

endmodule

FILE: hw/rtl/rqkr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqkr_cell: one queue slot
// Holds one entry. On a shift it takes the entry of its neighbor toward the
// tail; when addressed with a load it takes the load entry instead.
// ----------------------------------------------------------------------------
module rqkr_cell #(
  parameter int DEPTH = rqkr_pkg::DEPTH_DEFAULT,
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  rqkr_pkg::cell_ctl_t         ctl,
  input  logic [$clog2(DEPTH)-1:0]    target,
  input  rqkr_pkg::entry_t            load_word,
  input  rqkr_pkg::entry_t            next_word,
  output rqkr_pkg::entry_t            word
);
  import rqkr_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic hit;

  // This cell is the one addressed by the load.
  assign hit = ctl.load && (target == IDX_W'(INDEX));

  // A load wins over the shift so that a rotated entry lands at the tail.
  always_ff @(posedge clk) begin
    if (hit) begin
      word <= load_word;
    end else if (ctl.shift) begin
      word <= next_word;
    end
  end

endmodule

FILE: hw/rtl/rqkr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqkr_ctrl: command sequencer for the request queue
// Decodes commands, keeps the entry count and runs the rotation walk that
// serves tail removal and keyed removal through the head cell.
// ----------------------------------------------------------------------------
module rqkr_ctrl #(
  parameter int DEPTH = rqkr_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  rqkr_pkg::req_t              req,
  input  rqkr_pkg::entry_t            head,
  output logic                        busy,
  output logic                        done,
  output rqkr_pkg::rsp_t              rsp,
  output rqkr_pkg::cell_ctl_t         ctl,
  output logic [$clog2(DEPTH)-1:0]    target,
  output rqkr_pkg::entry_t            load_word
);
  import rqkr_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [CNT_W-1:0]   len, len_next;
  logic [IDX_W-1:0]   step, step_next;
  logic               found, found_next;
  logic               done_next;
  rsp_t               rsp_next;
  cmd_t               wcmd, wcmd_next;
  logic [KEY_W-1:0]   wkey, wkey_next;
  entry_t             taken, taken_next;
  logic               last;
  logic               drop;

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      len   <= '0;
      step  <= '0;
      found <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      len   <= len_next;
      step  <= step_next;
      found <= found_next;
      done  <= done_next;
    end
  end

  // Payload registers of the walk and the result word.
  always_ff @(posedge clk) begin
    rsp   <= rsp_next;
    wcmd  <= wcmd_next;
    wkey  <= wkey_next;
    taken <= taken_next;
  end

  // Next state, cell control and result.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    len_next   = len;
    step_next  = step;
    found_next = found;
    done_next  = 1'b0;
    rsp_next   = rsp;
    wcmd_next  = wcmd;
    wkey_next  = wkey;
    taken_next = taken;
    ctl        = '0;
    target     = '0;
    load_word  = head;
    busy       = 1'b0;
    last       = (CNT_W'(step) == cnt - CNT_W'(1));
    drop       = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          done_next        = 1'b1;
          rsp_next.status  = ST_OK;
          rsp_next.out_fd  = '0;
          rsp_next.out_stamp = '0;
          rsp_next.count   = COUNT_W'(cnt);
          case (cmd_t'(req.cmd))
            CMD_APPEND: begin
              if (cnt == CNT_W'(DEPTH)) begin
                rsp_next.status = ST_FULL;
              end else begin
                ctl.load        = 1'b1;
                target          = IDX_W'(cnt);
                load_word.key   = req.key_fd;
                load_word.stamp = req.arrival_stamp;
                cnt_next        = cnt + CNT_W'(1);
                rsp_next.count  = COUNT_W'(cnt + CNT_W'(1));
              end
            end
            CMD_POP_HEAD: begin
              if (cnt == '0) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                ctl.shift          = 1'b1;
                rsp_next.out_fd    = head.key;
                rsp_next.out_stamp = head.stamp;
                cnt_next           = cnt - CNT_W'(1);
                rsp_next.count     = COUNT_W'(cnt - CNT_W'(1));
              end
            end
            CMD_POP_TAIL, CMD_REMOVE_KEY: begin
              if (cnt == '0) begin
                rsp_next.status = (cmd_t'(req.cmd) == CMD_POP_TAIL) ? ST_EMPTY
                                                                    : ST_NOT_FOUND;
              end else begin
                // Start a walk of one rotation step per held entry.
                done_next  = 1'b0;
                state_next = S_WALK;
                wcmd_next  = cmd_t'(req.cmd);
                wkey_next  = req.key_fd;
                len_next   = cnt;
                step_next  = '0;
                found_next = 1'b0;
              end
            end
            default: begin
              rsp_next.status = ST_NOT_FOUND;
            end
          endcase
        end
      end

      S_WALK: begin
        busy = 1'b1;
        // The head entry leaves; it is dropped or re-entered at the tail.
        if (wcmd == CMD_POP_TAIL) begin
          drop = last;
        end else begin
          drop = !found && (head.key == wkey);
        end
        ctl.shift = 1'b1;
        ctl.load  = !drop;
        target    = IDX_W'(len - CNT_W'(1));
        step_next = step + IDX_W'(1);
        if (drop) begin
          len_next   = len - CNT_W'(1);
          found_next = 1'b1;
          taken_next = head;
        end
        if (last) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          found_next = 1'b0;
          if (found || drop) begin
            rsp_next.status    = ST_OK;
            rsp_next.out_fd    = drop ? head.key : taken.key;
            rsp_next.out_stamp = drop ? head.stamp : taken.stamp;
            rsp_next.count     = COUNT_W'(cnt - CNT_W'(1));
            cnt_next           = cnt - CNT_W'(1);
          end else begin
            rsp_next.status    = ST_NOT_FOUND;
            rsp_next.out_fd    = '0;
            rsp_next.out_stamp = '0;
            rsp_next.count     = COUNT_W'(cnt);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A result only follows an accepted command or the end of a walk.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(state == S_WALK)))
    else $error("result strobe without a cause");

  // The entry count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // During a walk at most one entry has been dropped.
  a_walk_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> ((len == cnt) || (len + CNT_W'(1) == cnt)))
    else $error("walk length out of step with count");

  // An empty report carries no entry and a zero count.
  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_EMPTY) |->
      (rsp.out_fd == '0 && rsp.out_stamp == '0 && rsp.count == '0))
    else $error("empty status with data");

endmodule
